### rtl/core/least_served_first_seat_scheduler_macros.svh
// assertion macros for the least-served-first seat scheduler checker
// no dependencies; taken in by the checker file
`ifndef LEAST_SERVED_FIRST_SEAT_SCHEDULER_MACROS_SVH
`define LEAST_SERVED_FIRST_SEAT_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSFS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LSFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/lsfs_pkg.sv
// types and codes shared by the least-served-first seat scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lsfs_pkg;

   // command codes
   localparam logic [1:0] CMD_ARRIVE = 2'd0;
   localparam logic [1:0] CMD_SERVE  = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   // result status codes
   localparam logic [2:0] RSP_SEATED      = 3'd0;
   localparam logic [2:0] RSP_FULL        = 3'd1;
   localparam logic [2:0] RSP_QUOTA_DONE  = 3'd2;
   localparam logic [2:0] RSP_SERVED      = 3'd3;
   localparam logic [2:0] RSP_QUEUE_EMPTY = 3'd4;
   localparam logic [2:0] RSP_SESS_ENDED  = 3'd5;
   localparam logic [2:0] RSP_NO_SESSION  = 3'd6;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEAT_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HELP_QUOTA = 1'b1;

   localparam logic [4:0] SEAT_LIMIT_RESET = 5'd4;
   localparam logic [7:0] HELP_QUOTA_RESET = 8'd3;
   localparam logic [7:0] COUNT_MAX        = 8'hFF;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LOOK  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   typedef struct packed {
      logic       scan_start;
      logic       insert;
      logic       pop;
      logic [5:0] client;
      logic [7:0] visits;
   } queue_ctl_type;

   typedef struct packed {
      logic scan_busy;
      logic empty;
      logic full;
   } queue_stat_type;

endpackage

`default_nettype wire

### rtl/core/lsfs_queue.sv
// sorted waiting queue: shift-register entries, one compare per cycle for the insert search
// depends on lsfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsfs_queue #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lsfs_pkg::queue_ctl_type            ctl,
   output lsfs_pkg::queue_stat_type                stat,
   output logic [$clog2(QUEUE_DEPTH)-1:0]          pos,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]        length,
   output logic [5:0]                              head_client
);

   localparam int unsigned QW = $clog2(QUEUE_DEPTH);
   localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);

   logic [5:0]    q_cli_ff [QUEUE_DEPTH];
   logic [7:0]    q_vis_ff [QUEUE_DEPTH];
   logic [QW-1:0] pos_ff;
   logic [QW-1:0] pos_in;
   logic [LW-1:0] len_ff;
   logic [LW-1:0] len_in;
   logic          scan_ff;
   logic          scan_in;
   logic          step_ok;

   // entries below the length are sorted, so the first miss ends the search
   assign step_ok = (LW'(pos_ff) < len_ff) && (q_vis_ff[pos_ff] <= ctl.visits);

   always_comb begin
      pos_in  = pos_ff;
      scan_in = scan_ff;
      len_in  = len_ff;
      if (ctl.scan_start) begin
         pos_in  = '0;
         scan_in = 1'b1;
      end else if (scan_ff) begin
         if (step_ok) begin
            pos_in = pos_ff + 1'b1;
         end else begin
            scan_in = 1'b0;
         end
      end
      if (ctl.insert) begin
         len_in = len_ff + 1'b1;
      end else if (ctl.pop) begin
         len_in = len_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         scan_ff <= 1'b0;
         len_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         scan_ff <= scan_in;
         len_ff  <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.insert) begin
         for (int i = QUEUE_DEPTH - 1; i > 0; i--) begin
            if (QW'(i) == pos_ff) begin
               q_cli_ff[i] <= ctl.client;
               q_vis_ff[i] <= ctl.visits;
            end else if (QW'(i) > pos_ff) begin
               q_cli_ff[i] <= q_cli_ff[i-1];
               q_vis_ff[i] <= q_vis_ff[i-1];
            end
         end
         if (pos_ff == '0) begin
            q_cli_ff[0] <= ctl.client;
            q_vis_ff[0] <= ctl.visits;
         end
      end else if (ctl.pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_cli_ff[i] <= q_cli_ff[i+1];
            q_vis_ff[i] <= q_vis_ff[i+1];
         end
      end
   end

   assign stat.scan_busy = scan_ff;
   assign stat.empty     = (len_ff == '0);
   assign stat.full      = (len_ff >= LW'(QUEUE_DEPTH));
   assign pos            = pos_ff;
   assign length         = len_ff;
   assign head_client    = q_cli_ff[0];

endmodule

`default_nettype wire

### rtl/core/least_served_first_seat_scheduler.sv
// sequence: an accepted word reads the client memories and is decided in the look state; a seated
// arrival then searches the queue, one compare per cycle, for its insert position, and the result
// is committed in the finish state, which waits while an earlier result is stalled; a new word is
// taken only after the previous one has committed.
// reset: synchronous, active high; afterwards a clearing pass sweeps the client memories
// while req_ready stays low (register writes are taken meanwhile).
`timescale 1ns / 1ps
`default_nettype none

module least_served_first_seat_scheduler #(
   parameter int unsigned MAX_CLIENTS = 64,
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned MAX_SERVERS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_command,
   input  wire logic [5:0]                         req_client_id,
   input  wire logic [3:0]                         req_server_id,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [2:0]                              rsp_status,
   output logic [3:0]                              rsp_queue_position,
   output logic [5:0]                              rsp_served_client,
   output logic [3:0]                              rsp_served_by,
   output logic [4:0]                              rsp_waiting_count,
   output logic [4:0]                              rsp_free_seats,
   output logic [31:0]                             rsp_request_total,
   output logic [31:0]                             rsp_session_total,
   input  wire logic                               csr_wr_en,
   input  wire logic [lsfs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [7:0]                         csr_wr_data
);

   localparam int unsigned CW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int unsigned QW = $clog2(QUEUE_DEPTH);
   localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);

   // client id modulo the client count, as a constant table
   function automatic logic [CW-1:0] client_wrap(input logic [5:0] v);
      logic [CW-1:0] r;
      int            w;
      r = '0;
      w = 0;
      for (int i = 0; i < 64; i++) begin
         if (v == 6'(i)) r = CW'(w);
         if (w == MAX_CLIENTS - 1) w = 0;
         else w = w + 1;
      end
      return r;
   endfunction

   function automatic logic [3:0] server_wrap(input logic [3:0] v);
      logic [3:0] r;
      int         w;
      r = '0;
      w = 0;
      for (int i = 0; i < 16; i++) begin
         if (v == 4'(i)) r = 4'(w);
         if (w == MAX_SERVERS - 1) w = 0;
         else w = w + 1;
      end
      return r;
   endfunction

   // free seats for a limit and a queue length, limit capped at the depth
   function automatic logic [LW-1:0] seats_for(input logic [4:0] limit, input logic [LW-1:0] len);
      logic [LW:0] lim;
      lim = (32'(limit) > QUEUE_DEPTH) ? (LW+1)'(QUEUE_DEPTH) : (LW+1)'(limit);
      return (lim > {1'b0, len}) ? LW'(lim - {1'b0, len}) : '0;
   endfunction

   lsfs_pkg::state_type      state_ff;
   lsfs_pkg::state_type      state_in;
   lsfs_pkg::queue_ctl_type  q_ctl;
   lsfs_pkg::queue_stat_type q_stat;
   logic [QW-1:0]            q_pos;
   logic [LW-1:0]            q_len;
   logic [5:0]               q_head;

   logic [CW-1:0]  clr_ff;
   logic [1:0]     cmd_ff;
   logic [CW-1:0]  cid_ff;
   logic [3:0]     sid_ff;
   logic [2:0]     status_ff;
   logic [7:0]     vis_new_ff;
   logic [7:0]     quota_new_ff;
   logic [4:0]     seat_limit_ff;
   logic [7:0]     help_quota_ff;
   logic [LW-1:0]  seats_free_ff;
   logic [31:0]    req_total_ff;
   logic [31:0]    sess_total_ff;

   // client memories: visit count and quota use in one word, session flag apart
   logic [15:0]    cli_mem [MAX_CLIENTS];
   logic           ses_mem [MAX_CLIENTS];
   logic [15:0]    cli_rd_ff;
   logic           ses_rd_ff;
   logic           cli_we;
   logic [CW-1:0]  cli_wa;
   logic [15:0]    cli_wd;
   logic           ses_we;
   logic [CW-1:0]  ses_wa;
   logic           ses_wd;

   logic           rsp_valid_ff;
   logic [2:0]     rsp_status_ff;
   logic [3:0]     rsp_pos_ff;
   logic [5:0]     rsp_client_ff;
   logic [3:0]     rsp_by_ff;
   logic [4:0]     rsp_wait_ff;
   logic [4:0]     rsp_seats_ff;

   logic           accept;
   logic           fin_go;
   logic           seated;
   logic           served;
   logic           ended;
   logic [LW-1:0]  len_new;
   logic [LW-1:0]  seats_new;
   logic [7:0]     cur_visit;
   logic [7:0]     cur_quota;

   assign req_ready = (state_ff == lsfs_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fin_go    = (state_ff == lsfs_pkg::ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign seated    = (cmd_ff == lsfs_pkg::CMD_ARRIVE) && (status_ff == lsfs_pkg::RSP_SEATED);
   assign served    = (cmd_ff == lsfs_pkg::CMD_SERVE) && (status_ff == lsfs_pkg::RSP_SERVED);
   assign ended     = (cmd_ff == lsfs_pkg::CMD_FINISH) &&
                      (status_ff == lsfs_pkg::RSP_SESS_ENDED);
   assign cur_visit = cli_rd_ff[15:8];
   assign cur_quota = cli_rd_ff[7:0];

   always_comb begin
      if (seated) begin
         len_new = q_len + 1'b1;
      end else if (served) begin
         len_new = q_len - 1'b1;
      end else begin
         len_new = q_len;
      end
      seats_new = seats_for(seat_limit_ff, len_new);
   end

   always_comb begin
      q_ctl.scan_start = 1'b0;
      q_ctl.insert     = fin_go && seated;
      q_ctl.pop        = fin_go && served;
      q_ctl.client     = 6'(cid_ff);
      q_ctl.visits     = vis_new_ff;
      if ((state_ff == lsfs_pkg::ST_LOOK) && (cmd_ff == lsfs_pkg::CMD_ARRIVE) &&
          (cur_quota < help_quota_ff) && (seats_free_ff != '0) && !q_stat.full) begin
         q_ctl.scan_start = 1'b1;
      end
   end

   lsfs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .ctl         (q_ctl),
      .stat        (q_stat),
      .pos         (q_pos),
      .length      (q_len),
      .head_client (q_head)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lsfs_pkg::ST_CLEAR: begin
            if (32'(clr_ff) == MAX_CLIENTS - 1) state_in = lsfs_pkg::ST_IDLE;
         end
         lsfs_pkg::ST_IDLE: begin
            if (accept) state_in = lsfs_pkg::ST_LOOK;
         end
         lsfs_pkg::ST_LOOK: begin
            state_in = q_ctl.scan_start ? lsfs_pkg::ST_SCAN : lsfs_pkg::ST_FIN;
         end
         lsfs_pkg::ST_SCAN: begin
            if (!q_stat.scan_busy) state_in = lsfs_pkg::ST_FIN;
         end
         lsfs_pkg::ST_FIN: begin
            if (fin_go) state_in = lsfs_pkg::ST_IDLE;
         end
         default: begin
            state_in = lsfs_pkg::ST_CLEAR;
         end
      endcase
   end

   // memory write selection: clearing sweep, or the commit of one word
   always_comb begin
      cli_we = 1'b0;
      cli_wa = cid_ff;
      cli_wd = {vis_new_ff, quota_new_ff};
      ses_we = 1'b0;
      ses_wa = cid_ff;
      ses_wd = 1'b0;
      if (state_ff == lsfs_pkg::ST_CLEAR) begin
         cli_we = 1'b1;
         cli_wa = clr_ff;
         cli_wd = '0;
         ses_we = 1'b1;
         ses_wa = clr_ff;
      end else if (fin_go) begin
         cli_we = seated;
         if (served) begin
            ses_we = 1'b1;
            ses_wa = client_wrap(q_head);
            ses_wd = 1'b1;
         end else if (ended) begin
            ses_we = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cli_we) cli_mem[cli_wa] <= cli_wd;
      if (ses_we) ses_mem[ses_wa] <= ses_wd;
      if (accept) begin
         cli_rd_ff <= cli_mem[client_wrap(req_client_id)];
         ses_rd_ff <= ses_mem[client_wrap(req_client_id)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lsfs_pkg::ST_CLEAR;
         clr_ff        <= '0;
         seat_limit_ff <= lsfs_pkg::SEAT_LIMIT_RESET;
         help_quota_ff <= lsfs_pkg::HELP_QUOTA_RESET;
         seats_free_ff <= seats_for(lsfs_pkg::SEAT_LIMIT_RESET, '0);
         req_total_ff  <= '0;
         sess_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == lsfs_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (fin_go) begin
            rsp_valid_ff  <= 1'b1;
            seats_free_ff <= seats_new;
            if (seated) req_total_ff <= req_total_ff + 32'd1;
            if (ended) sess_total_ff <= sess_total_ff + 32'd1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               lsfs_pkg::CSR_SEAT_LIMIT: begin
                  seat_limit_ff <= csr_wr_data[4:0];
                  seats_free_ff <= seats_for(csr_wr_data[4:0], q_len);
               end
               lsfs_pkg::CSR_HELP_QUOTA: begin
                  help_quota_ff <= csr_wr_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // item registers and decision
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         cid_ff <= client_wrap(req_client_id);
         sid_ff <= server_wrap(req_server_id);
      end
      if (state_ff == lsfs_pkg::ST_LOOK) begin
         vis_new_ff   <= (cur_visit < lsfs_pkg::COUNT_MAX) ? cur_visit + 8'd1 : cur_visit;
         quota_new_ff <= (cur_quota < lsfs_pkg::COUNT_MAX) ? cur_quota + 8'd1 : cur_quota;
         case (cmd_ff)
            lsfs_pkg::CMD_ARRIVE: begin
               if (cur_quota >= help_quota_ff) begin
                  status_ff <= lsfs_pkg::RSP_QUOTA_DONE;
               end else if ((seats_free_ff == '0) || q_stat.full) begin
                  status_ff <= lsfs_pkg::RSP_FULL;
               end else begin
                  status_ff <= lsfs_pkg::RSP_SEATED;
               end
            end
            lsfs_pkg::CMD_SERVE: begin
               status_ff <= q_stat.empty ? lsfs_pkg::RSP_QUEUE_EMPTY : lsfs_pkg::RSP_SERVED;
            end
            lsfs_pkg::CMD_FINISH: begin
               status_ff <= ses_rd_ff ? lsfs_pkg::RSP_SESS_ENDED : lsfs_pkg::RSP_NO_SESSION;
            end
            default: begin
               status_ff <= lsfs_pkg::RSP_NO_SESSION;
            end
         endcase
      end
      if (fin_go) begin
         rsp_status_ff <= status_ff;
         rsp_pos_ff    <= seated ? 4'(q_pos) : 4'd0;
         rsp_client_ff <= served ? q_head : 6'd0;
         rsp_by_ff     <= served ? sid_ff : 4'd0;
         rsp_wait_ff   <= 5'(len_new);
         rsp_seats_ff  <= 5'(seats_new);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_queue_position = rsp_pos_ff;
   assign rsp_served_client  = rsp_client_ff;
   assign rsp_served_by      = rsp_by_ff;
   assign rsp_waiting_count  = rsp_wait_ff;
   assign rsp_free_seats     = rsp_seats_ff;
   // totals are updated at the same commit as the result word
   assign rsp_request_total  = req_total_ff;
   assign rsp_session_total  = sess_total_ff;

endmodule

`default_nettype wire

### rtl/core/lsfs_checker.sv
// port-level checks for the least-served-first seat scheduler, bound to the top level
// depends on lsfs_pkg and least_served_first_seat_scheduler_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "least_served_first_seat_scheduler_macros.svh"

module lsfs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [5:0]  rsp_served_client,
   input wire logic [3:0]  rsp_served_by,
   input wire logic [31:0] rsp_request_total
);

   logic        reset_ff;
   logic        reset_fell;
   logic        req_take;
   logic        other_word;
   logic        serve_clear;
   logic        rsp_stall;
   logic [34:0] held_word;

   always_ff @(posedge clock) begin
      reset_ff <= reset;
   end

   assign reset_fell  = reset_ff && !reset;
   assign req_take    = req_valid && req_ready;
   assign other_word  = rsp_valid && (rsp_status != lsfs_pkg::RSP_SERVED);
   assign serve_clear = (rsp_served_client == 6'd0) && (rsp_served_by == 4'd0);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign held_word   = {rsp_status, rsp_request_total};

   // the clearing pass keeps the request side closed right after reset
   `LSFS_ASSERT_NOW(a_clear_after_reset, clock, 1'b0, reset_fell, !req_ready, "taken in clear pass")

   // one word at a time: ready drops after each accept
   `LSFS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_take, !req_ready, "ready after accept")

   // only a served word carries a client and server
   `LSFS_ASSERT_NOW(a_idle_fields, clock, reset, other_word, serve_clear, "serve fields set")

   // a stalled result word stays offered and holds
   `LSFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "stalled word dropped")
   `LSFS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(held_word), "word changed")

endmodule

bind least_served_first_seat_scheduler lsfs_checker u_lsfs_checker (.*);

`default_nettype wire
